// File: hw/rtl/spc_pkg.sv
// shared types and constants for the skin pixel classifier
`default_nettype none

package spc_pkg;

  // pixel component width
  localparam int unsigned PIX_W = 8;
  // hue threshold register width
  localparam int unsigned HUE_W = 9;

  // configuration register indexes
  localparam logic REG_HUE_LOW  = 1'b0;
  localparam logic REG_HUE_HIGH = 1'b1;

  // threshold reset values in degrees
  localparam logic [HUE_W-1:0] HUE_LOW_RST  = 9'd35;
  localparam logic [HUE_W-1:0] HUE_HIGH_RST = 9'd325;

  // bt.601 luma weights, 12 fraction bits
  localparam logic [19:0] Y_KR   = 20'd1225;
  localparam logic [19:0] Y_KG   = 20'd2404;
  localparam logic [19:0] Y_KB   = 20'd467;
  localparam logic [19:0] Y_RND  = 20'd2048;

  // chroma scale and offset (128 plus half an lsb), 12 fraction bits
  localparam logic signed [22:0] CR_SCALE = 23'sd2920;
  localparam logic signed [22:0] CB_SCALE = 23'sd2310;
  localparam logic signed [22:0] C_OFFSET = 23'sd526336;

  // cr/cb line bounds: 4096*cr against slope*cb + offset
  localparam logic signed [24:0] B1_SLOPE  = 25'sd6497;
  localparam logic signed [24:0] B1_OFFSET = 25'sd81920;
  localparam logic signed [24:0] B2_SLOPE  = 25'sd1412;
  localparam logic signed [24:0] B2_OFFSET = 25'sd312143;
  localparam logic signed [24:0] B3_SLOPE  = -25'sd18699;
  localparam logic signed [24:0] B3_OFFSET = 25'sd960779;
  localparam logic signed [24:0] B4_SLOPE  = -25'sd4710;
  localparam logic signed [24:0] B4_OFFSET = 25'sd1235968;
  localparam logic signed [24:0] B5_SLOPE  = -25'sd9362;
  localparam logic signed [24:0] B5_OFFSET = 25'sd1772954;

  // results of the five cr/cb line tests
  typedef struct packed {
    logic upper_steep;   // cr below the rising line
    logic lower_rise;    // cr above the shallow rising line
    logic lower_fall;    // cr above the falling line
    logic upper_fall;    // cr below the shallow falling line
    logic upper_far;     // cr below the far falling line
  } bounds_t;

endpackage

`default_nettype wire

// File: hw/rtl/skin_pixel_classifier.sv
// Skin pixel classifier: one RGB pixel per clock through a four-stage pipeline.
// A pixel is skin when the RGB lighting rule, five BT.601 Cr/Cb line bounds and
// the hue window (hue below hue_low or above hue_high, in degrees) all pass; a
// skin pixel leaves unchanged, any other leaves as black, with is_skin on tuser.
// Throughput is one pixel per clock unless the output stalls; a beat goes through
// stages 0 to 3 to the master side. Each stage has its own valid bit and moves
// forward when the next one is empty or moving, so s_tready drops only when all four
// stages hold pixels and the output is stalled. Cfg index 0 is hue_low, 1 is hue_high.
// The user writes thresholds only while the pipeline is empty; the block does not check.
`default_nettype none

module skin_pixel_classifier (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [8:0]  cfg_data,
  // pixel in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
  // pixel out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // out_red [7:0], out_green [15:8], out_blue [23:16]
  output logic             m_tuser    // is_skin [0]
);
  import spc_pkg::*;

  // threshold registers
  logic [HUE_W-1:0] hue_low;
  logic [HUE_W-1:0] hue_high;

  // stage valid bits and moves
  logic v0, v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  // stage 0 payload
  logic [PIX_W-1:0] r0, g0, b0;

  // stage 1 payload
  logic [PIX_W-1:0] r1, g1, b1, y1;
  logic             rgb1;
  logic [16:0]      num1;
  logic [PIX_W-1:0] d1;

  // stage 2 payload
  logic [PIX_W-1:0] r2, g2, b2, cr2, cb2;
  logic             rgb2, hue2;

  // stage 1 combinational
  logic [19:0]        y_sum;
  logic [PIX_W-1:0]   mx, mn, dlt, rg_abs;
  logic               day_ok, flash_ok;
  logic signed [18:0] r_s, g_s, b_s, d_s, num_raw, num_pos;

  // stage 2 combinational
  logic signed [22:0] cr_t, cb_t;
  logic [PIX_W-1:0]   cr_c, cb_c;
  logic [16:0]        lo_prod, hi_prod;

  // stage 3 combinational
  bounds_t bnd;
  logic    skin;

  // handshake: each stage moves when the next can take its beat
  assign rdy3     = !v3 || m_tready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = !v0 || rdy1;
  assign m_tvalid = v3;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hue_low  <= HUE_LOW_RST;
      hue_high <= HUE_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HUE_LOW:  hue_low  <= cfg_data;
        REG_HUE_HIGH: hue_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (s_tready) v0 <= s_tvalid;
      if (rdy1)     v1 <= v0;
      if (rdy2)     v2 <= v1;
      if (rdy3)     v3 <= v2;
    end
  end

  // stage 0: input register
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      r0 <= s_tdata[7:0];
      g0 <= s_tdata[15:8];
      b0 <= s_tdata[23:16];
    end
  end

  // stage 1: luma, extremes, rgb rule and hue numerator
  always_comb begin
    y_sum = 20'(r0) * Y_KR + 20'(g0) * Y_KG + 20'(b0) * Y_KB + Y_RND;

    mx = (r0 > g0) ? r0 : g0;
    mn = (r0 < g0) ? r0 : g0;
    if (b0 > mx) mx = b0;
    if (b0 < mn) mn = b0;
    dlt    = mx - mn;
    rg_abs = (r0 >= g0) ? (r0 - g0) : (g0 - r0);

    day_ok   = (r0 > 8'd95) && (g0 > 8'd40) && (b0 > 8'd20) && (dlt > 8'd15) &&
               (rg_abs > 8'd15) && (r0 > g0) && (r0 > b0);
    flash_ok = (r0 > 8'd220) && (g0 > 8'd210) && (b0 > 8'd170) &&
               (rg_abs <= 8'd15) && (r0 > b0) && (g0 > b0);

    r_s = $signed({11'b0, r0});
    g_s = $signed({11'b0, g0});
    b_s = $signed({11'b0, b0});
    d_s = $signed({11'b0, dlt});

    // sector by largest component, red first
    if (mx == r0) begin
      num_raw = 19'sd60 * (g_s - b_s);
    end else if (mx == g0) begin
      num_raw = 19'sd120 * d_s + 19'sd60 * (b_s - r_s);
    end else begin
      num_raw = 19'sd240 * d_s + 19'sd60 * (r_s - g_s);
    end
    num_pos = (num_raw < 19'sd0) ? (num_raw + 19'sd360 * d_s) : num_raw;
  end

  always_ff @(posedge clk) begin
    if (rdy1 && v0) begin
      r1   <= r0;
      g1   <= g0;
      b1   <= b0;
      y1   <= y_sum[19:12];
      rgb1 <= day_ok || flash_ok;
      // grey pixel: hue taken as zero over a unit denominator
      if (dlt == '0) begin
        num1 <= '0;
        d1   <= 8'd1;
      end else begin
        num1 <= num_pos[16:0];
        d1   <= dlt;
      end
    end
  end

  // stage 2: chroma with clamping and hue window
  always_comb begin
    cr_t = ($signed({15'b0, r1}) - $signed({15'b0, y1})) * CR_SCALE + C_OFFSET;
    cb_t = ($signed({15'b0, b1}) - $signed({15'b0, y1})) * CB_SCALE + C_OFFSET;

    if (cr_t < 23'sd0)        cr_c = '0;
    else if (|cr_t[22:20])    cr_c = 8'hFF;
    else                      cr_c = cr_t[19:12];

    if (cb_t < 23'sd0)        cb_c = '0;
    else if (|cb_t[22:20])    cb_c = 8'hFF;
    else                      cb_c = cb_t[19:12];

    lo_prod = {8'b0, hue_low}  * {9'b0, d1};
    hi_prod = {8'b0, hue_high} * {9'b0, d1};
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      r2   <= r1;
      g2   <= g1;
      b2   <= b1;
      cr2  <= cr_c;
      cb2  <= cb_c;
      rgb2 <= rgb1;
      hue2 <= (num1 < lo_prod) || (num1 > hi_prod);
    end
  end

  // stage 3: cr/cb bounds and output register
  spc_bounds u_bounds (
    .cr     (cr2),
    .cb     (cb2),
    .bounds (bnd)
  );

  assign skin = rgb2 && hue2 && (&bnd);

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      m_tdata <= skin ? {b2, g2, r2} : '0;
      m_tuser <= skin;
    end
  end

`ifndef ASSERT_OFF
  // a pixel that is not skin always leaves black
  a_black: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("non-skin beat carries pixel data");

  // input stalls only when every stage holds a pixel
  a_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> v0 && v1 && v2 && v3 && !m_tready)
    else $error("input stalled with room in the pipeline");

  // a stalled output beat is never dropped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !m_tready |=> v3)
    else $error("output beat lost while stalled");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/spc_bounds.sv
// five linear cr/cb bound tests, evaluated exactly in fixed point
`default_nettype none

module spc_bounds (
  input  wire logic [spc_pkg::PIX_W-1:0] cr,
  input  wire logic [spc_pkg::PIX_W-1:0] cb,
  output spc_pkg::bounds_t               bounds
);
  import spc_pkg::*;

  logic signed [24:0] crs;
  logic signed [24:0] cbs;

  // cr scaled to 12 fraction bits, cb as a signed operand
  assign crs = $signed({5'b0, cr, 12'b0});
  assign cbs = $signed({17'b0, cb});

  // line tests
  always_comb begin
    bounds.upper_steep = crs <= (cbs * B1_SLOPE + B1_OFFSET);
    bounds.lower_rise  = crs >= (cbs * B2_SLOPE + B2_OFFSET);
    bounds.lower_fall  = crs >= (cbs * B3_SLOPE + B3_OFFSET);
    bounds.upper_fall  = crs <= (cbs * B4_SLOPE + B4_OFFSET);
    bounds.upper_far   = crs <= (cbs * B5_SLOPE + B5_OFFSET);
  end

endmodule

`default_nettype wire

// File: dv/tb.sv
// testbench for the skin pixel classifier: directed and random pixels against a local predictor
`default_nettype none

module tb;
  import spc_pkg::*;

  localparam int HUE_LOW_AT_RESET  = 35;
  localparam int HUE_HIGH_AT_RESET = 325;
  localparam int STALL_LIMIT       = 2000;
  localparam int SETTLE_CYCLES     = 8;

  // expected output pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       skin;
  } pixel_verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_HUE_LOW;
  logic [8:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // red [7:0], green [15:8], blue [23:16]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // out_red [7:0], out_green [15:8], out_blue [23:16]
  logic        m_tuser;        // is_skin [0]

  pixel_verdict_t pending_verdicts[$];
  int hue_low_now  = HUE_LOW_AT_RESET;
  int hue_high_now = HUE_HIGH_AT_RESET;
  int errors = 0;
  int quiet_cycles = 0;
  bit src_idle = 1'b1;
  bit sink_idle = 1'b1;

  skin_pixel_classifier uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // chroma from a component minus luma, rounded and clamped to 0..255
  function automatic int chroma_of(input int diff, input int scale);
    int t;
    t = diff * scale + 128 * 4096 + 2048;
    if (t < 0) return 0;
    t = t >>> 12;
    return (t > 255) ? 255 : t;
  endfunction

  // rgb rule, cr/cb bounds and hue window; black unless all three pass
  function automatic pixel_verdict_t classify_pixel(input logic [7:0] r8, input logic [7:0] g8,
                                                    input logic [7:0] b8, input int lo,
                                                    input int hi);
    int r, g, b, mx, mn, d, rg, y, cr, cb, crs, num;
    bit day, flash, rgb_ok, crcb_ok, hue_ok;
    pixel_verdict_t v;
    r = int'(r8);
    g = int'(g8);
    b = int'(b8);
    mx = (r > g) ? r : g;
    mn = (r < g) ? r : g;
    if (b > mx) mx = b;
    if (b < mn) mn = b;
    d = mx - mn;
    rg = (r > g) ? r - g : g - r;
    day = r > 95 && g > 40 && b > 20 && d > 15 && rg > 15 && r > g && r > b;
    flash = r > 220 && g > 210 && b > 170 && rg <= 15 && r > b && g > b;
    rgb_ok = day || flash;
    // bt.601 chroma in 12 fraction bits
    y = (1225 * r + 2404 * g + 467 * b + 2048) >>> 12;
    cr = chroma_of(r - y, 2920);
    cb = chroma_of(b - y, 2310);
    crs = cr * 4096;
    crcb_ok = (crs <= 6497 * cb + 81920) && (crs >= 1412 * cb + 312143) &&
              (crs >= -18699 * cb + 960779) && (crs <= -4710 * cb + 1235968) &&
              (crs <= -9362 * cb + 1772954);
    // hue kept as num / d so the threshold compare is exact
    if (d == 0) begin
      num = 0;
      d = 1;
    end else if (mx == r) begin
      num = 60 * (g - b);
    end else if (mx == g) begin
      num = 120 * d + 60 * (b - r);
    end else begin
      num = 240 * d + 60 * (r - g);
    end
    if (num < 0) num += 360 * d;
    hue_ok = (num < lo * d) || (num > hi * d);
    v.skin  = rgb_ok && crcb_ok && hue_ok;
    v.red   = v.skin ? r8 : 8'd0;
    v.green = v.skin ? g8 : 8'd0;
    v.blue  = v.skin ? b8 : 8'd0;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 50) $display("error at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // register writes, accepted pixels, output beats and the watchdog
  always @(posedge clk) begin : monitor
    pixel_verdict_t want;
    bit moved;
    moved = 1'b0;
    if (rst) begin
      hue_low_now  = HUE_LOW_AT_RESET;
      hue_high_now = HUE_HIGH_AT_RESET;
    end else begin
      if (cfg_we) begin
        moved = 1'b1;
        if (cfg_index == REG_HUE_LOW) hue_low_now = int'(cfg_data);
        else if (cfg_index == REG_HUE_HIGH) hue_high_now = int'(cfg_data);
      end
      if (s_tvalid && s_tready) begin
        moved = 1'b1;
        pending_verdicts.push_back(classify_pixel(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16],
                                                  hue_low_now, hue_high_now));
      end
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        if (pending_verdicts.size() == 0) begin
          report_mismatch("output beat with nothing pending, is_skin", int'(m_tuser), 0);
        end else begin
          want = pending_verdicts.pop_front();
          if (m_tdata[7:0] !== want.red)
            report_mismatch("out_red", int'(m_tdata[7:0]), int'(want.red));
          if (m_tdata[15:8] !== want.green)
            report_mismatch("out_green", int'(m_tdata[15:8]), int'(want.green));
          if (m_tdata[23:16] !== want.blue)
            report_mismatch("out_blue", int'(m_tdata[23:16]), int'(want.blue));
          if (m_tuser !== want.skin)
            report_mismatch("is_skin", int'(m_tuser), int'(want.skin));
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("skin_pixel_classifier: mismatch");
      $finish;
    end
  end

  // output side: random stall before each beat while sink_idle is set
  initial begin : sink
    int stall;
    forever begin
      stall = sink_idle ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // one pixel beat after a random gap while src_idle is set; valid stays up when the gap is zero
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    gap = src_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, g, r};
    do @(posedge clk); while (!s_tready);
  endtask

  // stop sending and let the pipeline empty
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both thresholds in back-to-back writes, pipeline idle
  task automatic set_thresholds(input logic [8:0] lo, input logic [8:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HUE_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= REG_HUE_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly daylight and flash style pixels, the rest unrestricted
  task automatic send_mixed_pixel();
    int r, g, b, pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      r = $urandom_range(96, 255);
      g = $urandom_range(41, r - 16);
      b = $urandom_range(21, g);
    end else if (pick < 75) begin
      r = $urandom_range(221, 255);
      g = $urandom_range((r - 15 > 211) ? r - 15 : 211, (r + 15 < 255) ? r + 15 : 255);
      b = $urandom_range(171, ((r < g) ? r : g) - 1);
    end else begin
      r = $urandom_range(0, 255);
      g = $urandom_range(0, 255);
      b = $urandom_range(0, 255);
    end
    send_pixel(r[7:0], g[7:0], b[7:0]);
  endtask

  // corners of the pixel space and the named special cases at reset thresholds
  task automatic test_directed_pixels();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);     // grey, hue taken as zero
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'h55, 8'hAA, 8'h55);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'd200, 8'd120, 8'd90);      // typical daylight skin
    send_pixel(8'd240, 8'd230, 8'd200);     // flash lighting
    send_pixel(8'd230, 8'd225, 8'd180);
    send_pixel(8'd200, 8'd100, 8'd120);     // red largest, blue above green: negative hue wraps around by adding 360
    send_pixel(8'd160, 8'd135, 8'd100);     // hue exactly 35
    send_pixel(8'd160, 8'd134, 8'd100);     // hue just under 35
    send_pixel(8'd96, 8'd41, 8'd21);        // daylight rule at its lower edges
    send_pixel(8'd95, 8'd41, 8'd21);
    send_pixel(8'd221, 8'd211, 8'd171);     // flash rule at its lower edges
    wait_drained();
  endtask

  // threshold extremes, including values beyond 360
  task automatic test_threshold_extremes();
    logic [8:0] lows[6]  = '{9'd0, 9'd511, 9'd360, 9'd0, 9'd361, 9'd35};
    logic [8:0] highs[6] = '{9'd360, 9'd511, 9'd0, 9'd0, 9'd359, 9'd325};
    for (int k = 0; k < 6; k++) begin
      set_thresholds(lows[k], highs[k]);
      send_pixel(8'd160, 8'd135, 8'd100);
      send_pixel(8'd200, 8'd100, 8'd120);
      for (int n = 0; n < 30; n++) send_mixed_pixel();
      wait_drained();
    end
  endtask

  // random stretches with changing idling and thresholds between them
  task automatic test_random_stretches();
    logic [8:0] lo, hi;
    for (int s = 0; s < 8; s++) begin
      case ($urandom_range(0, 3))
        0: begin src_idle = 1'b1; sink_idle = 1'b1; end
        1: begin src_idle = 1'b0; sink_idle = 1'b0; end
        2: begin src_idle = 1'b1; sink_idle = 1'b0; end
        default: begin src_idle = 1'b0; sink_idle = 1'b1; end
      endcase
      lo = 9'($urandom_range(0, 100));
      hi = 9'($urandom_range(250, 360));
      if (s == 3) lo = 9'($urandom_range(0, 511));
      if (s == 5) hi = 9'($urandom_range(0, 511));
      set_thresholds(lo, hi);
      for (int n = 0; n < 70; n++) send_mixed_pixel();
      wait_drained();
    end
    src_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  // sender holds off mid stream until every result is back, then resumes
  task automatic test_mid_stream_drain();
    set_thresholds(9'd35, 9'd325);
    for (int n = 0; n < 20; n++) send_mixed_pixel();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    for (int n = 0; n < 20; n++) send_mixed_pixel();
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_pixels();
    test_threshold_extremes();
    test_random_stretches();
    test_mid_stream_drain();
    if (errors == 0) begin
      $display("skin_pixel_classifier: match");
    end else begin
      $display("skin_pixel_classifier: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: skin_pixel_classifier.f
hw/rtl/spc_pkg.sv
hw/rtl/spc_bounds.sv
hw/rtl/skin_pixel_classifier.sv
dv/tb.sv
